// ===== rtl/core/joystick_differential_drive_mixer_assert.svh =====
// Assertion macros for the joystick drive mixer.
// Included by the RTL files that check their own logic; needs nothing else.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define JDDM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define JDDM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `JDDM_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define JDDM_ASSERT(lbl, clk, rstn, prop, msg)
`define JDDM_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/core/jddm_pkg.sv =====
// Shared types, constants and divider tables for the joystick drive mixer.
// No dependencies; every module of the block uses it.
package jddm_pkg;

  // Stick and servo constants
  localparam logic [7:0] DEAD_LOW      = 8'd117;
  localparam logic [7:0] DEAD_HIGH     = 8'd137;
  localparam logic [7:0] STOP_VAL      = 8'd90;
  localparam logic [7:0] FULL_VAL      = 8'd180;
  localparam logic [7:0] DIR_LEFT_MAX  = 8'd150;
  localparam logic [7:0] DIR_RIGHT_MIN = 8'd30;
  localparam logic [7:0] MULT_BACK     = 8'd100;
  localparam logic [7:0] MULT_FWD      = 8'd80;
  localparam logic [7:0] FWD_EDGE      = 8'd91;
  localparam logic [7:0] AXIS_MAX      = 8'd255;
  localparam logic [7:0] THR_SPAN      = FULL_VAL - STOP_VAL;
  localparam logic [7:0] STEER_SPAN    = DIR_LEFT_MAX - STOP_VAL;

  localparam logic [15:0] LIMIT_RESET = 16'd500;

  // Divisors of the mapping and mixing steps
  localparam int unsigned DIVISOR_UP      = int'(DEAD_LOW);
  localparam int unsigned DIVISOR_DOWN    = int'(AXIS_MAX) - int'(DEAD_HIGH);
  localparam int unsigned DIVISOR_FWD_L   = int'(DIR_LEFT_MAX) - int'(FWD_EDGE);
  localparam int unsigned DIVISOR_FWD_R   = int'(FWD_EDGE) - int'(DIR_RIGHT_MIN);
  localparam int unsigned DIVISOR_BACK    = int'(DIR_LEFT_MAX) - int'(STOP_VAL);
  localparam int unsigned DIVISOR_PERCENT = 100;

  // Reciprocals, floor(2^RECIP_SHIFT / d); estimate is q or q-1
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 11;
  localparam int unsigned PROD_W      = 14;
  localparam int unsigned RECIP_UP      = (1 << RECIP_SHIFT) / DIVISOR_UP;
  localparam int unsigned RECIP_DOWN    = (1 << RECIP_SHIFT) / DIVISOR_DOWN;
  localparam int unsigned RECIP_FWD_L   = (1 << RECIP_SHIFT) / DIVISOR_FWD_L;
  localparam int unsigned RECIP_FWD_R   = (1 << RECIP_SHIFT) / DIVISOR_FWD_R;
  localparam int unsigned RECIP_BACK    = (1 << RECIP_SHIFT) / DIVISOR_BACK;
  localparam int unsigned RECIP_PERCENT = (1 << RECIP_SHIFT) / DIVISOR_PERCENT;

  // Lamp bit positions
  localparam int unsigned LAMP_GREEN_BIT  = 0;
  localparam int unsigned LAMP_YELLOW_BIT = 1;
  localparam int unsigned LAMP_RED_BIT    = 2;
  localparam int unsigned LAMP_ENABLE_BIT = 3;

  // Tick queue, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned CFG_IDX_W = PADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = CFG_IDX_W'(0);

  typedef enum logic [1:0] {
    KIND_MIX,
    KIND_STOP,
    KIND_HOLD
  } kind_e;

  typedef enum logic [2:0] {
    DIV_UP,
    DIV_DOWN,
    DIV_FWD_L,
    DIV_FWD_R,
    DIV_BACK,
    DIV_PERCENT
  } div_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] steer;
    logic [7:0] thr;
    logic [3:0] lamps;
    logic       drop;
  } entry_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic [3:0] lamps;
    logic       drop;
  } res_t;

  function automatic logic [6:0] div_value(div_e sel);
    logic [6:0] d;
    unique case (sel)
      DIV_UP:      d = 7'(DIVISOR_UP);
      DIV_DOWN:    d = 7'(DIVISOR_DOWN);
      DIV_FWD_L:   d = 7'(DIVISOR_FWD_L);
      DIV_FWD_R:   d = 7'(DIVISOR_FWD_R);
      DIV_BACK:    d = 7'(DIVISOR_BACK);
      DIV_PERCENT: d = 7'(DIVISOR_PERCENT);
      default:     d = 7'(DIVISOR_PERCENT);
    endcase
    return d;
  endfunction

  function automatic logic [RECIP_W-1:0] div_recip(div_e sel);
    logic [RECIP_W-1:0] r;
    unique case (sel)
      DIV_UP:      r = RECIP_W'(RECIP_UP);
      DIV_DOWN:    r = RECIP_W'(RECIP_DOWN);
      DIV_FWD_L:   r = RECIP_W'(RECIP_FWD_L);
      DIV_FWD_R:   r = RECIP_W'(RECIP_FWD_R);
      DIV_BACK:    r = RECIP_W'(RECIP_BACK);
      DIV_PERCENT: r = RECIP_W'(RECIP_PERCENT);
      default:     r = RECIP_W'(RECIP_PERCENT);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/jddm_muldiv.sv =====
// Three-stage multiply and constant-divide unit: q = (a * b) / d, d from a table.
// Depends on jddm_pkg for divisors and reciprocals.
module jddm_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          a_i,
  input  logic [7:0]          b_i,
  input  jddm_pkg::div_e      sel_i,
  output logic                done_o,
  output logic [7:0]          q_o
);

  localparam int unsigned T_W = jddm_pkg::PROD_W + jddm_pkg::RECIP_W;
  localparam int unsigned EST_W = T_W - jddm_pkg::RECIP_SHIFT;

  logic                         v1_q, v2_q, v3_q;
  logic [jddm_pkg::PROD_W-1:0]  p1_q, p2_q;
  jddm_pkg::div_e               sel1_q, sel2_q;
  logic [T_W-1:0]               t2_q;
  logic [7:0]                   q3_q;

  logic [15:0]                  prod_full;
  logic [EST_W-1:0]             est;
  logic [EST_W+6:0]             est_prod;
  logic [jddm_pkg::PROD_W-1:0]  rem;
  logic [6:0]                   dval;
  logic [EST_W-1:0]             q_full;

  // Correct the reciprocal estimate by one compare and subtract
  always_comb begin
    prod_full = a_i * b_i;
    est       = t2_q[T_W-1:jddm_pkg::RECIP_SHIFT];
    dval      = jddm_pkg::div_value(sel2_q);
    est_prod  = est * dval;
    rem       = p2_q - est_prod[jddm_pkg::PROD_W-1:0];
    q_full    = est + EST_W'(rem >= jddm_pkg::PROD_W'(dval));
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    p1_q   <= prod_full[jddm_pkg::PROD_W-1:0];
    sel1_q <= sel_i;
    t2_q   <= p1_q * jddm_pkg::div_recip(sel1_q);
    p2_q   <= p1_q;
    sel2_q <= sel1_q;
    q3_q   <= q_full[7:0];
  end

  assign done_o = v3_q;
  assign q_o    = q3_q;

endmodule

// ===== rtl/core/jddm_queue.sv =====
// Short tick queue between the classifying front and the mixing back.
// Depends on jddm_pkg for the entry type and depth.
module jddm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jddm_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output jddm_pkg::entry_t entry_o
);

  jddm_pkg::entry_t                 slot_q [jddm_pkg::QUEUE_DEPTH];
  logic [jddm_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [jddm_pkg::QCNT_W-1:0]      count_q;

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = (count_q == jddm_pkg::QCNT_W'(jddm_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

endmodule

// ===== rtl/core/jddm_front.sv =====
// Front end: accepts ticks, updates mode, link counter and lamps, classifies work.
// Depends on jddm_pkg; feeds jddm_queue.
module jddm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             link_up_i,
  input  logic             home_click_i,
  input  logic             auto_click_i,
  input  logic             manual_click_i,
  input  logic [7:0]       steer_axis_i,
  input  logic [7:0]       throttle_axis_i,
  input  logic [15:0]      limit_i,
  input  logic             q_full_i,
  output logic             push_o,
  output jddm_pkg::entry_t entry_o
);

  logic        auto_mode_q, auto_mode_d;
  logic [15:0] lost_ticks_q, lost_ticks_d;
  logic [3:0]  lamp_q, lamp_d;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // Work out this tick's state update and queue entry
  always_comb begin
    auto_mode_d   = auto_mode_q;
    lost_ticks_d  = lost_ticks_q;
    lamp_d        = lamp_q;
    entry_o.kind  = jddm_pkg::KIND_STOP;
    entry_o.drop  = 1'b0;
    if (link_up_i) begin
      lost_ticks_d = '0;
      if (!home_click_i) begin
        if (auto_click_i) begin
          auto_mode_d = 1'b1;
        end
        if (manual_click_i) begin
          auto_mode_d = 1'b0;
        end
      end
      lamp_d = '0;
      if (auto_mode_d) begin
        lamp_d[jddm_pkg::LAMP_GREEN_BIT]  = 1'b1;
        lamp_d[jddm_pkg::LAMP_ENABLE_BIT] = 1'b1;
        entry_o.kind = jddm_pkg::KIND_HOLD;
      end else begin
        lamp_d[jddm_pkg::LAMP_YELLOW_BIT] = 1'b1;
        entry_o.kind = jddm_pkg::KIND_MIX;
      end
      entry_o.drop = home_click_i;
    end else begin
      if (lost_ticks_q != '1) begin
        lost_ticks_d = lost_ticks_q + 1'b1;
      end
      // Red only, keep the enable pin
      if (lost_ticks_d > limit_i) begin
        lamp_d = '0;
        lamp_d[jddm_pkg::LAMP_RED_BIT]    = 1'b1;
        lamp_d[jddm_pkg::LAMP_ENABLE_BIT] = lamp_q[jddm_pkg::LAMP_ENABLE_BIT];
      end
    end
    entry_o.steer = steer_axis_i;
    entry_o.thr   = throttle_axis_i;
    entry_o.lamps = lamp_d;
  end

  // Commit state on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_mode_q  <= 1'b0;
      lost_ticks_q <= '0;
      lamp_q       <= '0;
    end else if (accept) begin
      auto_mode_q  <= auto_mode_d;
      lost_ticks_q <= lost_ticks_d;
      lamp_q       <= lamp_d;
    end
  end

endmodule

// ===== rtl/core/jddm_back.sv =====
// Back end: maps sticks to speed and direction, mixes drives, holds the result beat.
// Depends on jddm_pkg, jddm_muldiv and the assertion header.
`include "joystick_differential_drive_mixer_assert.svh"

module jddm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  jddm_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jddm_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPD,
    S_DIR,
    S_MULT,
    S_SCALE,
    S_DONE
  } state_e;

  state_e            state_q;
  logic              busy_q;
  jddm_pkg::entry_t  entry_q;
  logic [7:0]        spd_q, dir_q, mult_q;
  logic [7:0]        held_l_q, held_r_q;
  logic              out_valid_q;
  jddm_pkg::res_t    res_q;

  logic              op_start, op_done;
  logic [7:0]        op_a, op_b, op_q;
  jddm_pkg::div_e    op_sel;
  logic              thr_low, thr_high, str_low, str_high;
  logic              fwd, dir_gt, dir_lt;
  logic [7:0]        wheel, mix_l, mix_r;

  jddm_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .sel_i   (op_sel),
    .done_o  (op_done),
    .q_o     (op_q)
  );

  assign thr_low  = entry_q.thr < jddm_pkg::DEAD_LOW;
  assign thr_high = entry_q.thr > jddm_pkg::DEAD_HIGH;
  assign str_low  = entry_q.steer < jddm_pkg::DEAD_LOW;
  assign str_high = entry_q.steer > jddm_pkg::DEAD_HIGH;
  assign fwd      = spd_q > jddm_pkg::STOP_VAL;
  assign dir_gt   = dir_q > jddm_pkg::STOP_VAL;
  assign dir_lt   = dir_q < jddm_pkg::STOP_VAL;

  assign pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign op_start = !busy_q && ((state_q == S_SPD) || (state_q == S_DIR) ||
                                (state_q == S_MULT) || (state_q == S_SCALE));

  // Select operands for the shared multiply-divide unit
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sel = jddm_pkg::DIV_PERCENT;
    unique case (state_q)
      S_SPD: begin
        op_b   = jddm_pkg::THR_SPAN;
        op_sel = thr_high ? jddm_pkg::DIV_DOWN : jddm_pkg::DIV_UP;
        if (thr_low) begin
          op_a = jddm_pkg::DEAD_LOW - entry_q.thr;
        end else if (thr_high) begin
          op_a = entry_q.thr - jddm_pkg::DEAD_HIGH;
        end
      end
      S_DIR: begin
        op_b   = jddm_pkg::STEER_SPAN;
        op_sel = str_high ? jddm_pkg::DIV_DOWN : jddm_pkg::DIV_UP;
        if (str_low) begin
          op_a = jddm_pkg::DEAD_LOW - entry_q.steer;
        end else if (str_high) begin
          op_a = entry_q.steer - jddm_pkg::DEAD_HIGH;
        end
      end
      S_MULT: begin
        op_b = fwd ? jddm_pkg::MULT_FWD : jddm_pkg::MULT_BACK;
        if (fwd) begin
          op_sel = dir_gt ? jddm_pkg::DIV_FWD_L : jddm_pkg::DIV_FWD_R;
        end else begin
          op_sel = jddm_pkg::DIV_BACK;
        end
        if (dir_gt) begin
          op_a = jddm_pkg::DIR_LEFT_MAX - dir_q;
        end else if (dir_lt) begin
          op_a = (fwd ? jddm_pkg::FWD_EDGE : jddm_pkg::STOP_VAL) - dir_q;
        end
      end
      S_SCALE: begin
        op_a   = fwd ? (spd_q - jddm_pkg::STOP_VAL) : (jddm_pkg::STOP_VAL - spd_q);
        op_b   = mult_q;
        op_sel = jddm_pkg::DIV_PERCENT;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // Slow the inside wheel of the turn
  always_comb begin
    wheel = fwd ? (jddm_pkg::STOP_VAL + op_q) : (jddm_pkg::STOP_VAL - op_q);
    if (spd_q == jddm_pkg::STOP_VAL) begin
      mix_l = jddm_pkg::STOP_VAL;
      mix_r = jddm_pkg::STOP_VAL;
    end else begin
      mix_l = dir_gt ? wheel : spd_q;
      mix_r = dir_lt ? wheel : spd_q;
    end
  end

  // Sequence one tick and hold the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      entry_q     <= '0;
      spd_q       <= jddm_pkg::STOP_VAL;
      dir_q       <= jddm_pkg::STOP_VAL;
      mult_q      <= '0;
      held_l_q    <= jddm_pkg::STOP_VAL;
      held_r_q    <= jddm_pkg::STOP_VAL;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      // Drop the result beat once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (op_start) begin
        busy_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            entry_q <= entry_i;
            if (entry_i.kind == jddm_pkg::KIND_STOP) begin
              held_l_q <= jddm_pkg::STOP_VAL;
              held_r_q <= jddm_pkg::STOP_VAL;
            end
            state_q <= (entry_i.kind == jddm_pkg::KIND_MIX) ? S_SPD : S_DONE;
          end
        end
        S_SPD: begin
          if (op_done) begin
            busy_q  <= 1'b0;
            spd_q   <= thr_low ? (jddm_pkg::STOP_VAL + op_q) : (jddm_pkg::STOP_VAL - op_q);
            state_q <= S_DIR;
          end
        end
        S_DIR: begin
          if (op_done) begin
            busy_q  <= 1'b0;
            dir_q   <= str_low ? (jddm_pkg::STOP_VAL + op_q) : (jddm_pkg::STOP_VAL - op_q);
            state_q <= S_MULT;
          end
        end
        S_MULT: begin
          if (op_done) begin
            busy_q  <= 1'b0;
            if (dir_gt) begin
              mult_q <= op_q;
            end else begin
              mult_q <= (fwd ? jddm_pkg::MULT_FWD : jddm_pkg::MULT_BACK) - op_q;
            end
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (op_done) begin
            busy_q   <= 1'b0;
            held_l_q <= mix_l;
            held_r_q <= mix_r;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            res_q.left  <= held_l_q;
            res_q.right <= held_r_q;
            res_q.lamps <= entry_q.lamps;
            res_q.drop  <= entry_q.drop;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `JDDM_ASSERT(a_done_while_busy, clk_i, rst_ni, op_done |-> busy_q, "unit result without request")
  `JDDM_ASSERT_NEVER(a_idle_not_busy, clk_i, rst_ni, (state_q == S_IDLE) && busy_q, "busy in idle")
  `JDDM_ASSERT(a_held_range, clk_i, rst_ni, (held_l_q <= jddm_pkg::FULL_VAL) && (held_r_q <= jddm_pkg::FULL_VAL), "drive out of range")

endmodule

// ===== rtl/core/joystick_differential_drive_mixer.sv =====
// Top level of the joystick differential-drive mixer: register port and channel wiring.
// Depends on jddm_pkg, jddm_front, jddm_queue and jddm_back.
//
//   channel  | signals                               | beat
//   ---------+---------------------------------------+---------------------------
//   tick in  | in_valid_i / in_ready_o, six fields   | link, clicks, two axes
//   drive out| out_valid_o / out_ready_i, seven flds | drives, lamps, drop request
//   register | psel/penable/pwrite/paddr/pwdata      | lost_link_limit at byte 0
//
// A manual-mode tick reaches the result register after four passes through the
// shared three-stage multiply-divide unit: speed, direction, turn and scale.
// Autonomous and lost-link ticks skip the unit. The front classifies a tick in the
// cycle it arrives; a two-beat queue lets it keep taking ticks while the back works.
// Reset gives manual mode, held drives at 90, a cleared result beat, lamps off and a limit of 500.
// A stalled result beat holds the back; the queue then fills and in_ready_o drops.
module joystick_differential_drive_mixer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         link_up_i,
  input  logic                         home_click_i,
  input  logic                         auto_click_i,
  input  logic                         manual_click_i,
  input  logic [7:0]                   steer_axis_i,
  input  logic [7:0]                   throttle_axis_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   left_drive_o,
  output logic [7:0]                   right_drive_o,
  output logic                         green_lamp_o,
  output logic                         yellow_lamp_o,
  output logic                         red_lamp_o,
  output logic                         auto_enable_o,
  output logic                         drop_link_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jddm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [15:0]                     limit_q;
  logic [jddm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic                            cfg_we;
  logic                            q_full, q_valid, push, pop;
  jddm_pkg::entry_t                push_entry, head_entry;
  jddm_pkg::res_t                  res;

  // Decode the register port
  assign cfg_idx = paddr[jddm_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (cfg_idx == jddm_pkg::CFG_IDX_LIMIT) ? {16'b0, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= jddm_pkg::LIMIT_RESET;
    end else if (cfg_we && (cfg_idx == jddm_pkg::CFG_IDX_LIMIT)) begin
      limit_q <= pwdata[15:0];
    end
  end

  jddm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .link_up_i       (link_up_i),
    .home_click_i    (home_click_i),
    .auto_click_i    (auto_click_i),
    .manual_click_i  (manual_click_i),
    .steer_axis_i    (steer_axis_i),
    .throttle_axis_i (throttle_axis_i),
    .limit_i         (limit_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  jddm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  jddm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // Spread the result beat over the output ports
  assign left_drive_o  = res.left;
  assign right_drive_o = res.right;
  assign green_lamp_o  = res.lamps[jddm_pkg::LAMP_GREEN_BIT];
  assign yellow_lamp_o = res.lamps[jddm_pkg::LAMP_YELLOW_BIT];
  assign red_lamp_o    = res.lamps[jddm_pkg::LAMP_RED_BIT];
  assign auto_enable_o = res.lamps[jddm_pkg::LAMP_ENABLE_BIT];
  assign drop_link_o   = res.drop;

endmodule

// ===== dv/joystick_differential_drive_mixer_checker.sv =====
`timescale 1ns / 100ps
// Drive-beat checker for the joystick mixer: predicts every result beat and compares it.
// Depends on jddm_pkg for the servo constants, lamp bit positions and register index.
module joystick_differential_drive_mixer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  logic                         link_up_i,
  input  logic                         home_click_i,
  input  logic                         auto_click_i,
  input  logic                         manual_click_i,
  input  logic [7:0]                   steer_axis_i,
  input  logic [7:0]                   throttle_axis_i,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [7:0]                   left_drive_o,
  input  logic [7:0]                   right_drive_o,
  input  logic                         green_lamp_o,
  input  logic                         yellow_lamp_o,
  input  logic                         red_lamp_o,
  input  logic                         auto_enable_o,
  input  logic                         drop_link_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jddm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           fail_count_o,
  output int                           beats_seen_o
);

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic       green;
    logic       yellow;
    logic       red;
    logic       enable;
    logic       drop;
  } drive_beat_t;

  // Mirror of the mixer state
  logic        auto_mode;
  logic [15:0] lost_ticks;
  logic [15:0] lost_limit;
  logic [7:0]  held_left;
  logic [7:0]  held_right;
  logic [3:0]  lamps;

  drive_beat_t drives_due[$];
  drive_beat_t want;
  int          errors;

  assign fail_count_o = errors;

  // Deadband, then a linear ramp away from stop on either side
  function automatic int unsigned axis_to_cmd(int unsigned v, int unsigned up_span,
                                              int unsigned down_span);
    if (v < jddm_pkg::DEAD_LOW)
      return jddm_pkg::STOP_VAL + (jddm_pkg::DEAD_LOW - v) * up_span / jddm_pkg::DEAD_LOW;
    if (v > jddm_pkg::DEAD_HIGH)
      return jddm_pkg::STOP_VAL - (v - jddm_pkg::DEAD_HIGH) * down_span /
             (jddm_pkg::AXIS_MAX - jddm_pkg::DEAD_HIGH);
    return jddm_pkg::STOP_VAL;
  endfunction

  // Slow the wheel on the inside of the turn
  function automatic void mix_wheels(input int unsigned spd, input int unsigned dir,
                                     output int unsigned l, output int unsigned r);
    int unsigned span;
    int unsigned pct;
    l = spd;
    r = spd;
    if (spd > jddm_pkg::STOP_VAL) begin
      span = spd - jddm_pkg::STOP_VAL;
      if (dir > jddm_pkg::STOP_VAL) begin
        pct = (jddm_pkg::DIR_LEFT_MAX - dir) * jddm_pkg::MULT_FWD /
              (jddm_pkg::DIR_LEFT_MAX - jddm_pkg::FWD_EDGE);
        l = span * pct / jddm_pkg::DIVISOR_PERCENT + jddm_pkg::STOP_VAL;
      end else if (dir < jddm_pkg::STOP_VAL) begin
        pct = jddm_pkg::MULT_FWD - (jddm_pkg::FWD_EDGE - dir) * jddm_pkg::MULT_FWD /
              (jddm_pkg::FWD_EDGE - jddm_pkg::DIR_RIGHT_MIN);
        r = span * pct / jddm_pkg::DIVISOR_PERCENT + jddm_pkg::STOP_VAL;
      end
    end else if (spd < jddm_pkg::STOP_VAL) begin
      span = jddm_pkg::STOP_VAL - spd;
      if (dir > jddm_pkg::STOP_VAL) begin
        pct = (jddm_pkg::DIR_LEFT_MAX - dir) * jddm_pkg::MULT_BACK /
              (jddm_pkg::DIR_LEFT_MAX - jddm_pkg::STOP_VAL);
        l = jddm_pkg::STOP_VAL - span * pct / jddm_pkg::DIVISOR_PERCENT;
      end else if (dir < jddm_pkg::STOP_VAL) begin
        pct = jddm_pkg::MULT_BACK - (jddm_pkg::STOP_VAL - dir) * jddm_pkg::MULT_BACK /
              (jddm_pkg::STOP_VAL - jddm_pkg::DIR_RIGHT_MIN);
        r = jddm_pkg::STOP_VAL - span * pct / jddm_pkg::DIVISOR_PERCENT;
      end
    end else begin
      l = jddm_pkg::STOP_VAL;
      r = jddm_pkg::STOP_VAL;
    end
  endfunction

  // Advance the mirrored state by one tick and return the beat it yields
  function automatic drive_beat_t predict_drive(logic link, logic home, logic go_auto,
                                                logic go_manual, logic [7:0] steer,
                                                logic [7:0] thr);
    drive_beat_t beat;
    int unsigned l;
    int unsigned r;
    beat.drop = 1'b0;
    if (link) begin
      lost_ticks = '0;
      // Home click drops the link and masks the mode clicks
      if (home) begin
        beat.drop = 1'b1;
      end else begin
        if (go_auto) auto_mode = 1'b1;
        if (go_manual) auto_mode = 1'b0;
      end
      lamps = '0;
      if (auto_mode) begin
        lamps[jddm_pkg::LAMP_GREEN_BIT]  = 1'b1;
        lamps[jddm_pkg::LAMP_ENABLE_BIT] = 1'b1;
      end else begin
        lamps[jddm_pkg::LAMP_YELLOW_BIT] = 1'b1;
        mix_wheels(axis_to_cmd(32'(thr), 32'(jddm_pkg::THR_SPAN), 32'(jddm_pkg::STOP_VAL)),
                   axis_to_cmd(32'(steer), 32'(jddm_pkg::STEER_SPAN),
                               32'(jddm_pkg::STOP_VAL - jddm_pkg::DIR_RIGHT_MIN)),
                   l, r);
        held_left  = l[7:0];
        held_right = r[7:0];
      end
    end else begin
      // Count lost ticks, saturating; red only once past the limit
      if (lost_ticks != 16'hFFFF) lost_ticks = lost_ticks + 16'd1;
      if (lost_ticks > lost_limit) begin
        lamps[jddm_pkg::LAMP_GREEN_BIT]  = 1'b0;
        lamps[jddm_pkg::LAMP_YELLOW_BIT] = 1'b0;
        lamps[jddm_pkg::LAMP_RED_BIT]    = 1'b1;
      end
      held_left  = jddm_pkg::STOP_VAL;
      held_right = jddm_pkg::STOP_VAL;
    end
    beat.left   = held_left;
    beat.right  = held_right;
    beat.green  = lamps[jddm_pkg::LAMP_GREEN_BIT];
    beat.yellow = lamps[jddm_pkg::LAMP_YELLOW_BIT];
    beat.red    = lamps[jddm_pkg::LAMP_RED_BIT];
    beat.enable = lamps[jddm_pkg::LAMP_ENABLE_BIT];
    return beat;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val,
                                      int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Watch the register port and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_mode  = 1'b0;
      lost_ticks = '0;
      lost_limit = jddm_pkg::LIMIT_RESET;
      held_left  = jddm_pkg::STOP_VAL;
      held_right = jddm_pkg::STOP_VAL;
      lamps      = '0;
      errors     = 0;
      drives_due.delete();
      beats_seen_o <= 0;
    end else begin
      // Track limit writes, check readback
      if (psel && penable && pready &&
          paddr[jddm_pkg::PADDR_W-1:2] == jddm_pkg::CFG_IDX_LIMIT) begin
        if (pwrite) lost_limit = pwdata[15:0];
        else check_field("lost_link_limit", {16'b0, lost_limit}, prdata);
      end
      if (in_valid_i && in_ready_o)
        drives_due.push_back(predict_drive(link_up_i, home_click_i, auto_click_i,
                                           manual_click_i, steer_axis_i, throttle_axis_i));
      // Compare each result beat with the oldest prediction
      if (out_valid_o && out_ready_i) begin
        beats_seen_o <= beats_seen_o + 1;
        if (drives_due.size() == 0) begin
          $error("drive beat with no tick waiting");
          errors++;
        end else begin
          want = drives_due.pop_front();
          check_field("left_drive", 32'(want.left), 32'(left_drive_o));
          check_field("right_drive", 32'(want.right), 32'(right_drive_o));
          check_field("green_lamp", 32'(want.green), 32'(green_lamp_o));
          check_field("yellow_lamp", 32'(want.yellow), 32'(yellow_lamp_o));
          check_field("red_lamp", 32'(want.red), 32'(red_lamp_o));
          check_field("auto_enable", 32'(want.enable), 32'(auto_enable_o));
          check_field("drop_link", 32'(want.drop), 32'(drop_link_o));
        end
      end
    end
  end

endmodule

// ===== dv/joystick_differential_drive_mixer_test.sv =====
`timescale 1ns / 100ps
// Top of the joystick mixer testbench: clock, reset, tick stimulus, register writes, verdict.
// Depends on jddm_pkg, the mixer RTL and joystick_differential_drive_mixer_checker.
module joystick_differential_drive_mixer_test;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_ready_o;
  logic                         link_up_i       = 1'b0;
  logic                         home_click_i    = 1'b0;
  logic                         auto_click_i    = 1'b0;
  logic                         manual_click_i  = 1'b0;
  logic [7:0]                   steer_axis_i    = '0;
  logic [7:0]                   throttle_axis_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i     = 1'b0;
  logic [7:0]                   left_drive_o;
  logic [7:0]                   right_drive_o;
  logic                         green_lamp_o;
  logic                         yellow_lamp_o;
  logic                         red_lamp_o;
  logic                         auto_enable_o;
  logic                         drop_link_o;
  logic                         psel            = 1'b0;
  logic                         penable         = 1'b0;
  logic                         pwrite          = 1'b0;
  logic [jddm_pkg::PADDR_W-1:0] paddr           = '0;
  logic [31:0]                  pwdata          = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  int                           fail_count_o;
  int                           beats_seen_o;

  logic gaps_on     = 1'b1;
  int   ticks_sent  = 0;
  int   stall_left  = 0;
  int   idle_cycles = 0;

  joystick_differential_drive_mixer i_dut (.*);

  joystick_differential_drive_mixer_checker i_checker (.*);

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stick positions: full range, around the deadband, or at the ends
  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(112, 142));
      1:       return $urandom_range(0, 1) ? 8'($urandom_range(0, 2))
                                           : 8'($urandom_range(253, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stall the result channel at random
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= pick_gap() - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold one tick beat until accepted, then maybe idle
  task automatic send_tick(input logic link, input logic home, input logic go_auto,
                           input logic go_manual, input logic [7:0] steer,
                           input logic [7:0] thr);
    in_valid_i      <= 1'b1;
    link_up_i       <= link;
    home_click_i    <= home;
    auto_click_i    <= go_auto;
    manual_click_i  <= go_manual;
    steer_axis_i    <= steer;
    throttle_axis_i <= thr;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every result beat
  task automatic drain();
    in_valid_i <= 1'b0;
    while (beats_seen_o != ticks_sent) @(posedge clk_i);
  endtask

  // Setup and access phase; the caller ends the transfer
  task automatic reg_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {jddm_pkg::CFG_IDX_LIMIT, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Write the lost-link limit while idle, then read it back
  task automatic set_limit(input logic [15:0] limit);
    drain();
    reg_access(1'b1, {16'($urandom), limit});
    reg_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly linked ticks with rare clicks and bursts of lost link
  task automatic random_ticks(input int count);
    int   lost_run;
    logic link;
    lost_run = 0;
    for (int k = 0; k < count; k++) begin
      if (lost_run == 0 && $urandom_range(0, 19) == 0) lost_run = $urandom_range(1, 25);
      link = (lost_run == 0);
      if (lost_run != 0) lost_run--;
      send_tick(link, $urandom_range(0, 15) == 0, $urandom_range(0, 9) == 0,
                $urandom_range(0, 11) == 0, pick_axis(), pick_axis());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: axis extremes and deadband edges in manual mode
    set_limit(16'd2);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd128, 8'd128);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd255);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd255, 8'd255);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd116, 8'd117);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd117, 8'd116);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd137, 8'd138);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd138, 8'd137);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd128, 8'd0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd128);
    // Both mode clicks: manual wins
    send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'd60, 8'd30);
    // Autonomous holds the drives; home click masks the manual click
    send_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'd128, 8'd255);
    send_tick(1'b1, 1'b1, 1'b0, 1'b1, 8'd10, 8'd10);
    // Lost link in autonomous mode: red past the limit, enable kept
    send_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd255, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd255);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0);
    // Back to manual; home click still mixes, masks the auto click
    send_tick(1'b1, 1'b0, 1'b0, 1'b1, 8'd200, 8'd40);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'd30, 8'd220);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'd90, 8'd10);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd255, 8'd255);

    // Random phases across limit settings
    set_limit(16'd0);
    random_ticks(200);
    set_limit(16'hFFFF);
    gaps_on <= 1'b0;
    random_ticks(100);
    gaps_on <= 1'b1;
    random_ticks(100);
    set_limit(16'($urandom_range(3, 30)));
    random_ticks(200);
    set_limit(jddm_pkg::LIMIT_RESET);
    random_ticks(130);

    // Widest limit: a short lost run never lights red
    set_limit(16'hFFFF);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0, 1'b0, pick_axis(), pick_axis());
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, pick_axis(), pick_axis());

    drain();
    repeat (30) @(posedge clk_i);
    if (fail_count_o == 0 && beats_seen_o == ticks_sent) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
